@@ design/secb_pkg.sv @@
// Shared types, constants and codes of the sheared periodic cell boundary.
package secb_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int WORD_BITS      = 32;
   localparam int LEN_BITS       = 31;
   localparam int STEP_BITS      = 17;
   localparam int CSR_INDEX_BITS = 3;
   localparam int SNAP_EPS_INT   = ((1 << FRAC_BITS) + 500) / 1000;

   typedef logic signed [WORD_BITS-1:0]   word_type;
   typedef logic signed [2*WORD_BITS-1:0] prod_type;
   typedef logic [LEN_BITS-1:0]           len_type;
   typedef logic [STEP_BITS-1:0]          step_type;
   typedef logic signed [1:0]             level_type;

   localparam word_type WORD_MAX     = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN     = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type ONE_Q        = word_type'(WORD_BITS'(1) << FRAC_BITS);
   localparam word_type NEG_ONE_Q    = -ONE_Q;
   localparam word_type SNAP_EPS     = word_type'(SNAP_EPS_INT);
   localparam word_type NEG_SNAP_EPS = -SNAP_EPS;

   localparam len_type  CELL_WIDTH_RESET    = len_type'(655360);
   localparam len_type  START_HEIGHT_RESET  = len_type'(655360);
   localparam word_type TARGET_HEIGHT_RESET = word_type'(-1);
   localparam word_type PRESSURE_RESET      = '0;
   localparam len_type  INV_VISC_RESET      = len_type'(65536);
   localparam word_type STRAIN_RATE_RESET   = '0;
   localparam step_type TIME_STEP_RESET     = step_type'(66);

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_CONTACT = 2'd1,
      ACT_GRAIN   = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CELL_WIDTH    = 3'd0,
      CSR_START_HEIGHT  = 3'd1,
      CSR_TARGET_HEIGHT = 3'd2,
      CSR_PRESSURE      = 3'd3,
      CSR_INV_VISC      = 3'd4,
      CSR_STRAIN_RATE   = 3'd5,
      CSR_TIME_STEP     = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NEG,
      ST_VY_MUL,
      ST_VY,
      ST_STEP_MUL,
      ST_HEIGHT,
      ST_VX_MUL,
      ST_VX,
      ST_SHIFT_MUL,
      ST_SHIFT_ADD,
      ST_SHIFT_FOLD,
      ST_FOLD_A,
      ST_WRAP_SHIFT,
      ST_FOLD_B,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_VY,
      MUL_STEP,
      MUL_VX,
      MUL_SHIFT
   } mul_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_NEG,
      OP_VY,
      OP_HEIGHT,
      OP_VX,
      OP_SHIFT_ADD,
      OP_SHIFT_FOLD,
      OP_FOLD_A,
      OP_WRAP_SHIFT,
      OP_FOLD_B,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        mul_en;
      mul_sel_type mul_sel;
   } cmd_type;

   typedef struct packed {
      logic float_mode;
   } status_type;

   typedef struct packed {
      len_type  cell_width;
      word_type target_height;
      word_type pressure;
      len_type  inv_visc;
      word_type strain_rate;
      step_type time_step;
   } cfg_type;

endpackage

@@ design/secb_req_if.sv @@
// Request channel of the sheared periodic cell boundary.
interface secb_req_if import secb_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] action;
   word_type   pos_x;
   word_type   pos_y;
   word_type   grain_vel_x;
   word_type   normal_stress;

   modport source (output valid, action, pos_x, pos_y, grain_vel_x, normal_stress,
                   input ready);
   modport sink (input valid, action, pos_x, pos_y, grain_vel_x, normal_stress,
                 output ready);
endinterface

@@ design/secb_rsp_if.sv @@
// Response channel of the sheared periodic cell boundary.
interface secb_rsp_if import secb_pkg::*; ();
   logic      valid;
   logic      ready;
   word_type  out_x;
   word_type  out_y;
   word_type  vel_offset_x;
   word_type  vel_offset_y;
   level_type level_step_x;
   level_type level_step_y;
   len_type   height_now;
   word_type  shift_now;

   modport source (output valid, out_x, out_y, vel_offset_x, vel_offset_y, level_step_x,
                   level_step_y, height_now, shift_now,
                   input ready);
   modport sink (input valid, out_x, out_y, vel_offset_x, vel_offset_y, level_step_x,
                 level_step_y, height_now, shift_now,
                 output ready);
endinterface

@@ design/secb_csr.sv @@
// Configuration register file of the sheared periodic cell boundary.
module secb_csr import secb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  word_type                  csr_data,
   output cfg_type                   cfg,
   output logic                      height_load,
   output len_type                   height_value
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in      = cfg_ff;
      height_load = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CELL_WIDTH:    cfg_in.cell_width    = csr_data[LEN_BITS-1:0];
            CSR_START_HEIGHT:  height_load          = 1'b1;
            CSR_TARGET_HEIGHT: cfg_in.target_height = csr_data;
            CSR_PRESSURE:      cfg_in.pressure      = csr_data;
            CSR_INV_VISC:      cfg_in.inv_visc      = csr_data[LEN_BITS-1:0];
            CSR_STRAIN_RATE:   cfg_in.strain_rate   = csr_data;
            CSR_TIME_STEP:     cfg_in.time_step     = csr_data[STEP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_width    <= CELL_WIDTH_RESET;
         cfg_ff.target_height <= TARGET_HEIGHT_RESET;
         cfg_ff.pressure      <= PRESSURE_RESET;
         cfg_ff.inv_visc      <= INV_VISC_RESET;
         cfg_ff.strain_rate   <= STRAIN_RATE_RESET;
         cfg_ff.time_step     <= TIME_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg          = cfg_ff;
   assign height_value = csr_data[LEN_BITS-1:0];

endmodule

@@ design/secb_ctrl.sv @@
// Sequencer that steps the datapath through a tick or a wrap and owns the handshakes.
module secb_ctrl import secb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '{op: OP_NONE, mul_en: 1'b0, mul_sel: MUL_VY};
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               unique case (req_action) inside
                  ACT_TICK:              state_in = status.float_mode ? ST_NEG : ST_VY;
                  ACT_CONTACT, ACT_GRAIN: state_in = ST_FOLD_A;
                  default:               state_in = ST_DONE;
               endcase
            end
         end
         ST_NEG: begin
            cmd.op   = OP_NEG;
            state_in = ST_VY_MUL;
         end
         ST_VY_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_VY;
            state_in    = ST_VY;
         end
         ST_VY: begin
            cmd.op   = OP_VY;
            state_in = ST_STEP_MUL;
         end
         ST_STEP_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_STEP;
            state_in    = ST_HEIGHT;
         end
         ST_HEIGHT: begin
            cmd.op   = OP_HEIGHT;
            state_in = ST_VX_MUL;
         end
         ST_VX_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_VX;
            state_in    = ST_VX;
         end
         ST_VX: begin
            cmd.op   = OP_VX;
            state_in = ST_SHIFT_MUL;
         end
         ST_SHIFT_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SHIFT;
            state_in    = ST_SHIFT_ADD;
         end
         ST_SHIFT_ADD: begin
            cmd.op   = OP_SHIFT_ADD;
            state_in = ST_SHIFT_FOLD;
         end
         ST_SHIFT_FOLD: begin
            cmd.op   = OP_SHIFT_FOLD;
            state_in = ST_DONE;
         end
         ST_FOLD_A: begin
            cmd.op   = OP_FOLD_A;
            state_in = ST_WRAP_SHIFT;
         end
         ST_WRAP_SHIFT: begin
            cmd.op   = OP_WRAP_SHIFT;
            state_in = ST_FOLD_B;
         end
         ST_FOLD_B: begin
            cmd.op   = OP_FOLD_B;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/secb_dpath.sv @@
// Datapath: cell state, shared multiplier, saturating updates and the response register.
module secb_dpath import secb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  cfg_type    cfg,
   input  logic       height_load,
   input  len_type    height_value,
   input  logic [1:0] req_action,
   input  word_type   req_pos_x,
   input  word_type   req_pos_y,
   input  word_type   req_grain_vel_x,
   input  word_type   req_normal_stress,
   output word_type   rsp_out_x,
   output word_type   rsp_out_y,
   output word_type   rsp_vel_offset_x,
   output word_type   rsp_vel_offset_y,
   output level_type  rsp_level_step_x,
   output level_type  rsp_level_step_y,
   output len_type    rsp_height_now,
   output word_type   rsp_shift_now
);

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return word_type'(s[WORD_BITS-1:0]);
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return word_type'(s[WORD_BITS-1:0]);
   endfunction

   function automatic word_type sat_mul(input prod_type p);
      prod_type q;
      q = p >>> FRAC_BITS;
      if ((&q[2*WORD_BITS-1:WORD_BITS-1]) || !(|q[2*WORD_BITS-1:WORD_BITS-1])) begin
         return word_type'(q[WORD_BITS-1:0]);
      end
      return q[2*WORD_BITS-1] ? WORD_MIN : WORD_MAX;
   endfunction

   function automatic word_type fold_half(input word_type x, input word_type w);
      word_type h;
      h = w >>> 1;
      if (x > h) begin
         return sat_sub(x, w);
      end
      if (x < -h) begin
         return sat_add(x, w);
      end
      return x;
   endfunction

   function automatic word_type fold_box(input word_type x, input word_type w);
      if (x > w) begin
         return sat_sub(x, w);
      end
      if (x[WORD_BITS-1]) begin
         return sat_add(x, w);
      end
      return x;
   endfunction

   word_type   height_ff, height_in;
   word_type   vel_x_ff, vel_x_in;
   word_type   vel_y_ff, vel_y_in;
   word_type   shift_ff, shift_in;
   action_type action_ff, action_in;
   word_type   x_ff, x_in;
   word_type   y_ff, y_in;
   word_type   acc_ff, acc_in;
   word_type   vox_ff, vox_in;
   word_type   voy_ff, voy_in;
   level_type  lx_ff, lx_in;
   level_type  ly_ff, ly_in;
   logic       move_ff, move_in;
   logic       up_ff, up_in;
   logic       down_ff, down_in;
   prod_type   prod_ff;
   word_type   out_x_ff, out_x_in;
   word_type   out_y_ff, out_y_in;
   word_type   out_vx_ff, out_vx_in;
   word_type   out_vy_ff, out_vy_in;
   level_type  out_lx_ff, out_lx_in;
   level_type  out_ly_ff, out_ly_in;

   word_type   width_w, dt_w, iv_w;
   word_type   mul_a, mul_b, mul_res;
   word_type   vy_float, height_step, half_height;
   logic       float_mode, is_grain;

   assign width_w     = word_type'({1'b0, cfg.cell_width});
   assign dt_w        = word_type'({{(WORD_BITS-STEP_BITS){1'b0}}, cfg.time_step});
   assign iv_w        = word_type'({1'b0, cfg.inv_visc});
   assign float_mode  = cfg.target_height[WORD_BITS-1];
   assign is_grain    = (action_ff == ACT_GRAIN);
   assign mul_res     = sat_mul(prod_ff);
   assign half_height = height_ff >>> 1;
   assign vy_float    = (mul_res > ONE_Q) ? ONE_Q :
                        ((mul_res < NEG_ONE_Q) ? NEG_ONE_Q : mul_res);
   assign height_step = sat_add(height_ff, sat_add(mul_res, mul_res));

   always_comb begin
      case (cmd.mul_sel)
         MUL_VY: begin
            mul_a = acc_ff;
            mul_b = iv_w;
         end
         MUL_STEP: begin
            mul_a = vel_y_ff;
            mul_b = dt_w;
         end
         MUL_VX: begin
            mul_a = height_ff;
            mul_b = cfg.strain_rate;
         end
         default: begin
            mul_a = vel_x_ff;
            mul_b = dt_w;
         end
      endcase
   end

   always_comb begin
      height_in = height_ff;
      vel_x_in  = vel_x_ff;
      vel_y_in  = vel_y_ff;
      shift_in  = shift_ff;
      action_in = action_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      vox_in    = vox_ff;
      voy_in    = voy_ff;
      lx_in     = lx_ff;
      ly_in     = ly_ff;
      move_in   = move_ff;
      up_in     = up_ff;
      down_in   = down_ff;
      out_x_in  = out_x_ff;
      out_y_in  = out_y_ff;
      out_vx_in = out_vx_ff;
      out_vy_in = out_vy_ff;
      out_lx_in = out_lx_ff;
      out_ly_in = out_ly_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            action_in = action_type'(req_action);
            x_in      = req_pos_x;
            y_in      = req_pos_y;
            vox_in    = req_grain_vel_x;
            acc_in    = float_mode ? sat_add(cfg.pressure, req_normal_stress)
                                   : sat_sub(cfg.target_height, height_ff);
         end
         OP_NEG: acc_in = sat_sub('0, acc_ff);
         OP_VY: begin
            if (float_mode) begin
               vel_y_in = vy_float;
               move_in  = 1'b1;
            end else if ((acc_ff > NEG_SNAP_EPS) && (acc_ff < SNAP_EPS)) begin
               height_in = cfg.target_height;
               vel_y_in  = '0;
               move_in   = 1'b0;
            end else begin
               vel_y_in = acc_ff[WORD_BITS-1] ? NEG_ONE_Q : ONE_Q;
               move_in  = 1'b1;
            end
         end
         OP_HEIGHT: begin
            if (move_ff) begin
               height_in = height_step[WORD_BITS-1] ? '0 : height_step;
            end
         end
         OP_VX:         vel_x_in = mul_res;
         OP_SHIFT_ADD:  acc_in   = sat_add(shift_ff, mul_res);
         OP_SHIFT_FOLD: shift_in = fold_half(acc_ff, width_w);
         OP_FOLD_A: begin
            up_in   = (y_ff > half_height);
            down_in = (y_ff < -half_height);
            if (y_ff > half_height) begin
               y_in = sat_sub(y_ff, height_ff);
            end else if (y_ff < -half_height) begin
               y_in = sat_add(y_ff, height_ff);
            end
            voy_in = '0;
            if (is_grain) begin
               x_in  = fold_box(x_ff, width_w);
               lx_in = (x_ff > width_w) ? level_type'(1) :
                       (x_ff[WORD_BITS-1] ? level_type'(-1) : level_type'(0));
               ly_in = (y_ff > half_height) ? level_type'(1) :
                       ((y_ff < -half_height) ? level_type'(-1) : level_type'(0));
            end else begin
               x_in  = fold_half(x_ff, width_w);
               lx_in = '0;
               ly_in = '0;
               vox_in = '0;
               if (y_ff > half_height) begin
                  vox_in = sat_sub('0, vel_x_ff);
                  voy_in = sat_sub('0, vel_y_ff);
               end else if (y_ff < -half_height) begin
                  vox_in = vel_x_ff;
                  voy_in = vel_y_ff;
               end
            end
         end
         OP_WRAP_SHIFT: begin
            if (up_ff) begin
               x_in = sat_sub(x_ff, shift_ff);
               if (is_grain) begin
                  vox_in = sat_sub(vox_ff, vel_x_ff);
               end
            end else if (down_ff) begin
               x_in = sat_add(x_ff, shift_ff);
               if (is_grain) begin
                  vox_in = sat_add(vox_ff, vel_x_ff);
               end
            end
         end
         OP_FOLD_B: x_in = is_grain ? fold_box(x_ff, width_w) : fold_half(x_ff, width_w);
         OP_OUT: begin
            out_x_in  = '0;
            out_y_in  = '0;
            out_vx_in = '0;
            out_vy_in = '0;
            out_lx_in = '0;
            out_ly_in = '0;
            case (action_ff) inside
               ACT_TICK: begin
                  out_vx_in = vel_x_ff;
                  out_vy_in = vel_y_ff;
               end
               ACT_CONTACT, ACT_GRAIN: begin
                  out_x_in  = x_ff;
                  out_y_in  = y_ff;
                  out_vx_in = vox_ff;
                  out_vy_in = voy_ff;
                  out_lx_in = lx_ff;
                  out_ly_in = ly_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      if (height_load) begin
         height_in = word_type'({1'b0, height_value});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= word_type'({1'b0, START_HEIGHT_RESET});
         vel_x_ff  <= '0;
         vel_y_ff  <= '0;
         shift_ff  <= '0;
         move_ff   <= 1'b0;
      end else begin
         height_ff <= height_in;
         vel_x_ff  <= vel_x_in;
         vel_y_ff  <= vel_y_in;
         shift_ff  <= shift_in;
         move_ff   <= move_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      vox_ff    <= vox_in;
      voy_ff    <= voy_in;
      lx_ff     <= lx_in;
      ly_ff     <= ly_in;
      up_ff     <= up_in;
      down_ff   <= down_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_vx_ff <= out_vx_in;
      out_vy_ff <= out_vy_in;
      out_lx_ff <= out_lx_in;
      out_ly_ff <= out_ly_in;
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         rsp_height_now <= height_ff[LEN_BITS-1:0];
         rsp_shift_now  <= shift_ff;
      end
   end

   assign status.float_mode = float_mode;
   assign rsp_out_x         = out_x_ff;
   assign rsp_out_y         = out_y_ff;
   assign rsp_vel_offset_x  = out_vx_ff;
   assign rsp_vel_offset_y  = out_vy_ff;
   assign rsp_level_step_x  = out_lx_ff;
   assign rsp_level_step_y  = out_ly_ff;

endmodule

@@ design/sheared_periodic_cell_boundary_core.sv @@
// Top level of the sheared periodic cell boundary: registers, sequencer and datapath.
// Each item is handled alone, one at a time, and all arithmetic is signed Q16.16 with
// saturation to 32 bits. A tick first negates the summed stress when the height floats
// under pressure, then forms four dependent products in turn (wall y velocity, height step,
// wall x velocity, shift increment) on one shared 32 by 32 multiplier, each product
// registered before its saturating update. A contact or grain wrap runs fold A, wrap shift
// and fold B; the unused action goes straight to the done state. The output step waits until
// the previous item has been taken from the response register. The next item is accepted
// while a finished item still waits in the response register. Writing the start height
// also loads the cell height.
module sheared_periodic_cell_boundary_core import secb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   secb_req_if.sink                  req_ch,
   secb_rsp_if.source                rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  word_type                  csr_data
);

   cfg_type    cfg;
   logic       height_load;
   len_type    height_value;
   cmd_type    cmd;
   status_type status;

   secb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg),
      .height_load  (height_load),
      .height_value (height_value)
   );

   secb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   secb_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg               (cfg),
      .height_load       (height_load),
      .height_value      (height_value),
      .req_action        (req_ch.action),
      .req_pos_x         (req_ch.pos_x),
      .req_pos_y         (req_ch.pos_y),
      .req_grain_vel_x   (req_ch.grain_vel_x),
      .req_normal_stress (req_ch.normal_stress),
      .rsp_out_x         (rsp_ch.out_x),
      .rsp_out_y         (rsp_ch.out_y),
      .rsp_vel_offset_x  (rsp_ch.vel_offset_x),
      .rsp_vel_offset_y  (rsp_ch.vel_offset_y),
      .rsp_level_step_x  (rsp_ch.level_step_x),
      .rsp_level_step_y  (rsp_ch.level_step_y),
      .rsp_height_now    (rsp_ch.height_now),
      .rsp_shift_now     (rsp_ch.shift_now)
   );

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while an item is still in progress");

   a_load_matches_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) == (req_ch.valid && req_ch.ready))
      else $error("datapath capture does not match request acceptance");

   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |=> rsp_ch.valid)
      else $error("response register loaded without raising valid");

   a_level_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.level_step_x != 2'b10) && (rsp_ch.level_step_y != 2'b10))
      else $error("level step outside minus one to plus one");

endmodule

@@ test/sheared_periodic_cell_boundary_core_tb.sv @@
// Self-checking testbench of the sheared periodic cell boundary core with its own predictor.
module sheared_periodic_cell_boundary_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import secb_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 10;

   localparam longint W_MAX = longint'(WORD_MAX);
   localparam longint W_MIN = longint'(WORD_MIN);
   localparam longint ONE   = longint'(ONE_Q);
   localparam longint EPS   = longint'(SNAP_EPS);
   localparam len_type LEN_MAX = '1;

   typedef struct {
      action_type action;
      word_type   pos_x;
      word_type   pos_y;
      word_type   grain_vel;
      word_type   stress;
   } cell_item_type;

   typedef struct {
      word_type  out_x;
      word_type  out_y;
      word_type  vel_x;
      word_type  vel_y;
      level_type lvl_x;
      level_type lvl_y;
      len_type   height;
      word_type  shift;
   } cell_result_type;

   typedef struct {
      len_type  cell_width;
      len_type  start_height;
      word_type target_height;
      word_type pressure;
      len_type  inv_visc;
      word_type strain_rate;
      step_type time_step;
   } cell_cfg_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   word_type csr_data;

   secb_req_if req_ch ();
   secb_rsp_if rsp_ch ();

   sheared_periodic_cell_boundary_core dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   longint width_q    = longint'(CELL_WIDTH_RESET);
   longint target_q   = longint'(TARGET_HEIGHT_RESET);
   longint press_q    = longint'(PRESSURE_RESET);
   longint inv_visc_q = longint'(INV_VISC_RESET);
   longint rate_q     = longint'(STRAIN_RATE_RESET);
   longint dt_q       = longint'(TIME_STEP_RESET);
   longint height_q   = longint'(START_HEIGHT_RESET);
   longint wall_vx    = 0;
   longint wall_vy    = 0;
   longint shift_q    = 0;

   cell_result_type pending_results[$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  idle_on = 1'b1;
   int  stall_left = 0;
   int  hold_requests = 0;
   int  holds_done = 0;
   logic hold_active = 1'b0;

   function automatic longint clamp_word(longint v);
      if (v > W_MAX) return W_MAX;
      if (v < W_MIN) return W_MIN;
      return v;
   endfunction

   function automatic longint add_sat(longint a, longint b);
      return clamp_word(a + b);
   endfunction

   function automatic longint sub_sat(longint a, longint b);
      return clamp_word(a - b);
   endfunction

   function automatic longint mul_q(longint a, longint b);
      return clamp_word((a * b) >>> FRAC_BITS);
   endfunction

   function automatic longint fold_centered(longint x, longint w);
      longint h;
      h = w >>> 1;
      if (x > h) return sub_sat(x, w);
      if (x < -h) return add_sat(x, w);
      return x;
   endfunction

   function automatic longint fold_box(longint x, longint w);
      if (x > w) return sub_sat(x, w);
      if (x < 0) return add_sat(x, w);
      return x;
   endfunction

   function automatic cell_result_type predict_cell(cell_item_type item_in);
      cell_result_type r;
      longint x, y, gv, vx, vy, incr, d, ad, hh, lx, ly;
      bit move_h;
      r = '{default: '0};
      x = item_in.pos_x;
      y = item_in.pos_y;
      gv = item_in.grain_vel;
      vx = 0;
      vy = 0;
      lx = 0;
      ly = 0;
      hh = height_q >>> 1;
      case (item_in.action)
         ACT_TICK: begin
            move_h = 1'b1;
            if (target_q < 0) begin
               vy = mul_q(sub_sat(0, add_sat(press_q, item_in.stress)), inv_visc_q);
               if (vy > ONE) vy = ONE;
               else if (vy < -ONE) vy = -ONE;
            end else begin
               d = sub_sat(target_q, height_q);
               ad = (d < 0) ? sub_sat(0, d) : d;
               if (d == 0 || ad < EPS) begin
                  height_q = target_q;
                  vy = 0;
                  move_h = 1'b0;
               end else begin
                  vy = (d > 0) ? ONE : -ONE;
               end
            end
            if (move_h) begin
               incr = mul_q(vy, dt_q);
               height_q = add_sat(height_q, add_sat(incr, incr));
            end
            if (height_q < 0) height_q = 0;
            wall_vy = vy;
            wall_vx = mul_q(height_q, rate_q);
            shift_q = fold_centered(add_sat(shift_q, mul_q(wall_vx, dt_q)), width_q);
            r.vel_x = word_type'(wall_vx);
            r.vel_y = word_type'(wall_vy);
         end
         ACT_CONTACT: begin
            x = fold_centered(x, width_q);
            if (y > hh) begin
               y = sub_sat(y, height_q);
               x = sub_sat(x, shift_q);
               vx = sub_sat(0, wall_vx);
               vy = sub_sat(0, wall_vy);
            end else if (y < -hh) begin
               y = add_sat(y, height_q);
               x = add_sat(x, shift_q);
               vx = wall_vx;
               vy = wall_vy;
            end
            r.out_x = word_type'(fold_centered(x, width_q));
            r.out_y = word_type'(y);
            r.vel_x = word_type'(vx);
            r.vel_y = word_type'(vy);
         end
         ACT_GRAIN: begin
            lx = (x > width_q) ? 1 : ((x < 0) ? -1 : 0);
            ly = (y > hh) ? 1 : ((y < -hh) ? -1 : 0);
            x = fold_box(x, width_q);
            if (y > hh) begin
               y = sub_sat(y, height_q);
               x = sub_sat(x, shift_q);
               gv = sub_sat(gv, wall_vx);
            end else if (y < -hh) begin
               y = add_sat(y, height_q);
               x = add_sat(x, shift_q);
               gv = add_sat(gv, wall_vx);
            end
            r.out_x = word_type'(fold_box(x, width_q));
            r.out_y = word_type'(y);
            r.vel_x = word_type'(gv);
            r.lvl_x = level_type'(lx);
            r.lvl_y = level_type'(ly);
         end
         default: begin
         end
      endcase
      r.height = len_type'(height_q);
      r.shift = word_type'(shift_q);
      return r;
   endfunction

   function automatic longint rand_between(longint lo, longint hi);
      bit [63:0] raw;
      raw = {$urandom, $urandom};
      return lo + longint'(raw % (hi - lo + 1));
   endfunction

   function automatic word_type pick_coord(longint span);
      longint side;
      side = ($urandom_range(0, 1) == 0) ? -1 : 1;
      case ($urandom_range(0, 11))
         0: return word_type'($urandom);
         1: return (side > 0) ? WORD_MAX : WORD_MIN;
         2: return word_type'(clamp_word(side * ((span >>> 1) + rand_between(-1, 1))));
         3: return word_type'(clamp_word(side * span + rand_between(-1, 1)));
         4: return word_type'(rand_between(-1, 1));
         default: return word_type'(clamp_word(rand_between(-2 * span, 2 * span)));
      endcase
   endfunction

   function automatic len_type pick_length();
      case ($urandom_range(0, 7))
         0: return len_type'(1);
         1: return LEN_MAX;
         2: return len_type'($urandom_range(1, 32'h7FFF_FFFF));
         default: return len_type'($urandom_range(1, 64 << FRAC_BITS));
      endcase
   endfunction

   function automatic cell_item_type random_item();
      cell_item_type item_out;
      item_out.action = ($urandom_range(0, 31) == 0) ? ACT_NOP
                                                     : action_type'($urandom_range(0, 2));
      item_out.pos_x = pick_coord(width_q);
      item_out.pos_y = pick_coord(height_q);
      item_out.grain_vel = ($urandom_range(0, 3) == 0) ? word_type'($urandom)
                                                       : word_type'(rand_between(-4 * ONE, 4 * ONE));
      item_out.stress = ($urandom_range(0, 2) == 0) ? word_type'($urandom)
                        : word_type'(clamp_word(-press_q + rand_between(-2 * ONE, 2 * ONE)));
      return item_out;
   endfunction

   function automatic cell_cfg_type random_cfg();
      cell_cfg_type c;
      longint t;
      c.cell_width = pick_length();
      c.start_height = pick_length();
      case ($urandom_range(0, 3))
         0, 1: c.target_height = word_type'(-1);
         2: begin
            t = longint'(c.start_height) + rand_between(-8 * ONE, 8 * ONE);
            if (t < 0) t = 0;
            c.target_height = word_type'(clamp_word(t));
         end
         default: c.target_height = word_type'($urandom_range(0, 32'h7FFF_FFFF));
      endcase
      c.pressure = ($urandom_range(0, 3) == 0) ? word_type'($urandom)
                                               : word_type'(rand_between(-2 * ONE, 2 * ONE));
      case ($urandom_range(0, 5))
         0: c.inv_visc = '0;
         1: c.inv_visc = len_type'(ONE);
         2: c.inv_visc = LEN_MAX;
         3: c.inv_visc = len_type'($urandom);
         default: c.inv_visc = len_type'(rand_between(0, 4 * ONE));
      endcase
      c.strain_rate = ($urandom_range(0, 3) == 0) ? word_type'($urandom)
                                                  : word_type'(rand_between(-ONE, ONE));
      case ($urandom_range(0, 4))
         0: c.time_step = '0;
         1: c.time_step = step_type'(65536);
         2: c.time_step = TIME_STEP_RESET;
         default: c.time_step = step_type'($urandom_range(0, 65536));
      endcase
      return c;
   endfunction

   function void check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   task automatic write_reg(csr_index_type idx, word_type value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_CELL_WIDTH: width_q = longint'(value[LEN_BITS-1:0]);
         CSR_START_HEIGHT: height_q = longint'(value[LEN_BITS-1:0]);
         CSR_TARGET_HEIGHT: target_q = longint'(value);
         CSR_PRESSURE: press_q = longint'(value);
         CSR_INV_VISC: inv_visc_q = longint'(value[LEN_BITS-1:0]);
         CSR_STRAIN_RATE: rate_q = longint'(value);
         CSR_TIME_STEP: dt_q = longint'(value[STEP_BITS-1:0]);
         default: begin
         end
      endcase
   endtask

   task automatic configure(cell_cfg_type c, bit load_height);
      write_reg(CSR_CELL_WIDTH, word_type'(c.cell_width));
      if (load_height) write_reg(CSR_START_HEIGHT, word_type'(c.start_height));
      write_reg(CSR_TARGET_HEIGHT, c.target_height);
      write_reg(CSR_PRESSURE, c.pressure);
      write_reg(CSR_INV_VISC, word_type'(c.inv_visc));
      write_reg(CSR_STRAIN_RATE, c.strain_rate);
      write_reg(CSR_TIME_STEP, word_type'(c.time_step));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(cell_item_type item_in);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= item_in.action;
      req_ch.pos_x <= item_in.pos_x;
      req_ch.pos_y <= item_in.pos_y;
      req_ch.grain_vel_x <= item_in.grain_vel;
      req_ch.normal_stress <= item_in.stress;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(predict_cell(item_in));
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_values();
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, 0});
      send_item(cell_item_type'{ACT_CONTACT, word_type'(6 * ONE), word_type'(6 * ONE), 0, 0});
      send_item(cell_item_type'{ACT_GRAIN, word_type'(11 * ONE), word_type'(-6 * ONE),
                                word_type'(ONE), 0});
      send_item(cell_item_type'{ACT_NOP, word_type'($urandom), word_type'($urandom),
                                word_type'($urandom), word_type'($urandom)});
      wait_idle();
   endtask

   task automatic test_boundary_cases();
      cell_cfg_type c;
      longint w, hh;
      c = '{cell_width: len_type'(655360), start_height: len_type'(524288),
            target_height: word_type'(-1), pressure: ONE_Q, inv_visc: len_type'(ONE),
            strain_rate: word_type'(32768), time_step: step_type'(655)};
      configure(c, 1'b1);
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, 0});
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, WORD_MIN});
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, WORD_MAX});
      w = width_q;
      hh = height_q >>> 1;
      send_item(cell_item_type'{ACT_CONTACT, WORD_MAX, WORD_MAX, 0, 0});
      send_item(cell_item_type'{ACT_CONTACT, WORD_MIN, WORD_MIN, 0, 0});
      send_item(cell_item_type'{ACT_CONTACT, word_type'(w >>> 1), word_type'(hh), 0, 0});
      send_item(cell_item_type'{ACT_CONTACT, word_type'((w >>> 1) + 1), word_type'(hh + 1),
                                0, 0});
      send_item(cell_item_type'{ACT_CONTACT, word_type'(-(w >>> 1) - 1), word_type'(-hh - 1),
                                0, 0});
      send_item(cell_item_type'{ACT_CONTACT, word_type'(-(w >>> 1)), word_type'(-hh), 0, 0});
      send_item(cell_item_type'{ACT_GRAIN, word_type'(w), word_type'(hh), WORD_MIN, 0});
      send_item(cell_item_type'{ACT_GRAIN, word_type'(w + 1), word_type'(hh + 1), WORD_MIN, 0});
      send_item(cell_item_type'{ACT_GRAIN, word_type'(-1), word_type'(-hh - 1), WORD_MAX, 0});
      send_item(cell_item_type'{ACT_GRAIN, 0, word_type'(-hh), 0, 0});
      send_item(cell_item_type'{ACT_GRAIN, WORD_MAX, WORD_MIN, WORD_MAX, 0});
      send_item(cell_item_type'{ACT_GRAIN, WORD_MIN, WORD_MAX, WORD_MIN, 0});
      send_item(cell_item_type'{ACT_NOP, word_type'($urandom), word_type'($urandom),
                                word_type'($urandom), word_type'($urandom)});
      wait_idle();
   endtask

   task automatic test_height_targets();
      cell_cfg_type c;
      c = '{cell_width: len_type'(655360), start_height: len_type'(524288),
            target_height: word_type'(524288 + EPS - 1), pressure: word_type'(0),
            inv_visc: len_type'(ONE), strain_rate: word_type'(16384),
            time_step: step_type'(655)};
      configure(c, 1'b1);
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, 0});
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, 0});
      wait_idle();
      c.target_height = word_type'(height_q + EPS);
      configure(c, 1'b0);
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, 0});
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, 0});
      wait_idle();
      c.start_height = len_type'(100);
      c.target_height = word_type'(0);
      c.time_step = step_type'(65536);
      configure(c, 1'b1);
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, 0});
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, 0});
      wait_idle();
      c.start_height = len_type'(1);
      c.target_height = word_type'(-1);
      c.pressure = WORD_MAX;
      configure(c, 1'b1);
      send_item(cell_item_type'{ACT_TICK, 0, 0, 0, 0});
      wait_idle();
   endtask

   task automatic test_random_settings();
      cell_cfg_type c;
      for (int phase = 0; phase < 8; phase++) begin
         idle_on = (phase != 3);
         case (phase)
            2: c = '{cell_width: LEN_MAX, start_height: LEN_MAX, target_height: WORD_MAX,
                     pressure: WORD_MAX, inv_visc: LEN_MAX, strain_rate: WORD_MAX,
                     time_step: step_type'(65536)};
            5: c = '{cell_width: len_type'(1), start_height: len_type'(1),
                     target_height: word_type'(0), pressure: WORD_MIN, inv_visc: '0,
                     strain_rate: WORD_MIN, time_step: '0};
            default: c = random_cfg();
         endcase
         configure(c, phase == 0 || $urandom_range(0, 1) != 0);
         repeat (190) send_item(random_item());
         wait_idle();
      end
   endtask

   task automatic test_output_stall();
      idle_on = 1'b0;
      configure(random_cfg(), 1'b1);
      hold_requests++;
      repeat (150) send_item(random_item());
      wait_idle();
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      configure(random_cfg(), 1'b1);
      repeat (250) send_item(random_item());
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (hold_active) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin : output_hold
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
            holds_done++;
         end
      end
   end

   always @(posedge clock) begin : result_check
      cell_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result item with no prediction pending at cycle %0d", cycle_count);
         end else begin
            want = pending_results.pop_front();
            check_field("out_x", want.out_x, rsp_ch.out_x);
            check_field("out_y", want.out_y, rsp_ch.out_y);
            check_field("vel_offset_x", want.vel_x, rsp_ch.vel_offset_x);
            check_field("vel_offset_y", want.vel_y, rsp_ch.vel_offset_y);
            check_field("level_step_x", want.lvl_x, rsp_ch.level_step_x);
            check_field("level_step_y", want.lvl_y, rsp_ch.level_step_y);
            check_field("height_now", want.height, rsp_ch.height_now);
            check_field("shift_now", want.shift, rsp_ch.shift_now);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.action <= ACT_TICK;
      req_ch.pos_x <= '0;
      req_ch.pos_y <= '0;
      req_ch.grain_vel_x <= '0;
      req_ch.normal_stress <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_boundary_cases();
      test_height_targets();
      test_random_settings();
      test_output_stall();
      test_back_to_back();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
